// ===== design/region_table_define_check_core_macros.svh =====
// Assertion macros used by the region table checker file.
`ifndef REGION_TABLE_DEFINE_CHECK_CORE_MACROS_SVH
`define REGION_TABLE_DEFINE_CHECK_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rtdc_pkg.sv =====
// Shared types and constants for the region table define-check block.
`default_nettype none

package rtdc_pkg;

    localparam int unsigned MAX_REGIONS_DEF = 16;
    localparam int unsigned PAGE_SHIFT_DEF  = 12;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned LEN_W   = 33;
    localparam int unsigned END_W   = 34;
    localparam int unsigned PERM_W  = 3;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned ENTRY_W = ADDR_W + LEN_W + PERM_W;

    localparam logic [ADDR_W-1:0] LIMIT_RESET = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LIMIT   = 2'd1,
        ST_OVERLAP = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALIGN,
        S_ROUND,
        S_LIMIT,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic align;
        logic round;
        logic limit;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic fault;
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/region_table_define_check_core.sv =====
// Top level of the region table define-check block.
// A request accepted in S_IDLE passes S_ALIGN, S_ROUND, S_LIMIT and the overlap scan
// in S_SCAN before S_FINISH registers its result; past the user-space limit it skips S_SCAN.
// A new request is taken only after the last one has finished; the overlap scan reads
// one table entry per cycle, and a stalled result holds back only the next one.
// Reset (synchronous, active low) clears all valid bits and the region count and
// restores the user-space limit to 0x80000000; no clearing pass is needed.
`default_nettype none

module region_table_define_check_core
    import rtdc_pkg::*;
#(
    parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int unsigned PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [ADDR_W-1:0]   i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [ADDR_W-1:0]   i_base_address,
    input  wire logic [ADDR_W-1:0]   i_byte_length,
    input  wire logic                i_can_read,
    input  wire logic                i_can_write,
    input  wire logic                i_can_execute,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [1:0]               o_status,
    output logic [ADDR_W-1:0]        o_aligned_base,
    output logic [LEN_W-1:0]         o_aligned_length,
    output logic [COUNT_W-1:0]       o_regions_in_use
);

    t_cmd  cmd;
    t_stat stat;

    rtdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rtdc_dpath #(
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_base_address   (i_base_address),
        .i_byte_length    (i_byte_length),
        .i_can_read       (i_can_read),
        .i_can_write      (i_can_write),
        .i_can_execute    (i_can_execute),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_aligned_base   (o_aligned_base),
        .o_aligned_length (o_aligned_length),
        .o_regions_in_use (o_regions_in_use)
    );

endmodule

`default_nettype wire

// ===== design/rtdc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rtdc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/rtdc_ctrl.sv =====
// Controller state machine sequencing alignment, limit check, table scan and commit.
`default_nettype none

module rtdc_ctrl
    import rtdc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN:  n_state = S_ROUND;
            S_ROUND:  n_state = S_LIMIT;
            S_LIMIT: begin
                n_state = i_stat.fault ? S_FINISH : S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_ALIGN:  o_cmd.align = 1'b1;
            S_ROUND:  o_cmd.round = 1'b1;
            S_LIMIT:  o_cmd.limit = 1'b1;
            S_SCAN:   o_cmd.scan  = 1'b1;
            S_FINISH: o_cmd.finish = i_stat.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/rtdc_dpath.sv =====
// Datapath: page alignment, limit compare, overlap scan over the region RAM, result register.
`default_nettype none

module rtdc_dpath
    import rtdc_pkg::*;
#(
    parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int unsigned PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [ADDR_W-1:0]   i_cfg_wdata,
    input  wire logic [ADDR_W-1:0]   i_base_address,
    input  wire logic [ADDR_W-1:0]   i_byte_length,
    input  wire logic                i_can_read,
    input  wire logic                i_can_write,
    input  wire logic                i_can_execute,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [1:0]               o_status,
    output logic [ADDR_W-1:0]        o_aligned_base,
    output logic [LEN_W-1:0]         o_aligned_length,
    output logic [COUNT_W-1:0]       o_regions_in_use
);

    localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int unsigned CNT_W = ($clog2(MAX_REGIONS + 1) > COUNT_W) ?
                                    $clog2(MAX_REGIONS + 1) : COUNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_REGIONS - 1);
    localparam logic [LEN_W-1:0] PAGE_MASK = LEN_W'((64'd1 << PAGE_SHIFT) - 64'd1);

    logic [ADDR_W-1:0]      r_limit;
    logic [ADDR_W-1:0]      r_base;
    logic [ADDR_W-1:0]      r_len_raw;
    logic [LEN_W-1:0]       r_len33;
    logic [LEN_W-1:0]       r_len_al;
    logic [PERM_W-1:0]      r_perms;
    logic [END_W-1:0]       r_end;
    logic                   r_fault;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_pidx;
    logic                   r_pend;
    logic                   r_ovl;
    logic                   r_have_free;
    logic [IDX_W-1:0]       r_free;
    logic [MAX_REGIONS-1:0] r_valid;
    logic [CNT_W-1:0]       r_count;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [ADDR_W-1:0]      r_out_base;
    logic [LEN_W-1:0]       r_out_len;
    logic [COUNT_W-1:0]     r_out_count;

    logic [END_W-1:0]   n_end;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [END_W-1:0]   old_base;
    logic [END_W-1:0]   old_end;
    logic               cmp_en;
    t_status            n_status;
    logic               commit;
    logic [CNT_W-1:0]   n_count;

    assign n_end    = {2'b00, r_base} + {1'b0, r_len_al};
    assign old_base = {2'b00, ram_rdata[ADDR_W-1:0]};
    assign old_end  = old_base + {1'b0, ram_rdata[ADDR_W+LEN_W-1:ADDR_W]};
    assign cmp_en   = i_cmd.scan && r_pend;

    always_comb begin
        if (r_fault) begin
            n_status = ST_LIMIT;
        end else if (r_ovl) begin
            n_status = ST_OVERLAP;
        end else if (!r_have_free) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_OK;
        end
    end

    assign commit  = i_cmd.finish && (n_status == ST_OK);
    assign n_count = commit ? r_count + CNT_W'(1) : r_count;

    assign o_stat.fault     = n_end > {2'b00, r_limit};
    assign o_stat.scan_done = r_pend && (r_pidx == LAST_IDX);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    rtdc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_REGIONS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (commit),
        .i_waddr (r_free),
        .i_wdata ({r_perms, r_len_al, r_base}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_ovl       <= 1'b0;
            r_have_free <= 1'b0;
            r_fault     <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_pend      <= 1'b0;
                r_ovl       <= 1'b0;
                r_have_free <= 1'b0;
                r_idx       <= '0;
            end
            if (i_cmd.limit) begin
                r_fault <= o_stat.fault;
            end
            if (i_cmd.scan) begin
                r_idx  <= (r_idx == LAST_IDX) ? '0 : r_idx + IDX_W'(1);
                r_pend <= 1'b1;
            end
            if (cmp_en) begin
                if (r_valid[r_pidx]) begin
                    if (({2'b00, r_base} < old_end) && (old_base < r_end)) begin
                        r_ovl <= 1'b1;
                    end
                end else if (!r_have_free) begin
                    r_have_free <= 1'b1;
                end
            end
            if (commit) begin
                r_valid[r_free] <= 1'b1;
            end
            r_count <= n_count;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_base    <= i_base_address;
            r_len_raw <= i_byte_length;
            r_perms   <= {i_can_execute, i_can_write, i_can_read};
        end
        if (i_cmd.align) begin
            r_len33 <= {1'b0, r_len_raw} + ({1'b0, r_base} & PAGE_MASK);
            r_base  <= r_base & ~PAGE_MASK[ADDR_W-1:0];
        end
        if (i_cmd.round) begin
            r_len_al <= (r_len33 + PAGE_MASK) & ~PAGE_MASK;
        end
        if (i_cmd.limit) begin
            r_end <= n_end;
        end
        if (i_cmd.scan) begin
            r_pidx <= r_idx;
        end
        if (cmp_en && !r_valid[r_pidx] && !r_have_free) begin
            r_free <= r_pidx;
        end
        if (i_cmd.finish) begin
            r_out_status <= n_status;
            r_out_base   <= r_base;
            r_out_len    <= r_len_al;
            r_out_count  <= n_count[COUNT_W-1:0];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_aligned_base   = r_out_base;
    assign o_aligned_length = r_out_len;
    assign o_regions_in_use = r_out_count;

endmodule

`default_nettype wire

// ===== design/rtdc_chk.sv =====
// Port-level assertion checker for the region table define-check block, with its bind.
`default_nettype none

`include "region_table_define_check_core_macros.svh"

module rtdc_chk
    import rtdc_pkg::*;
#(
    parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int unsigned PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire logic [1:0]          o_status,
    input wire logic [ADDR_W-1:0]   o_aligned_base,
    input wire logic [LEN_W-1:0]    o_aligned_length,
    input wire logic [COUNT_W-1:0]  o_regions_in_use
);

    // A stalled result keeps its status and count until it is taken.
    `RTDC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_status) && $stable(o_regions_in_use),
        "Result changed while stalled.")

    // Every reported region is page aligned in base and length.
    `RTDC_ASSERT_NOW(a_aligned, i_clk, i_rst_n, o_out_valid,
        (o_aligned_base[PAGE_SHIFT-1:0] == '0) && (o_aligned_length[PAGE_SHIFT-1:0] == '0),
        "Reported region is not page aligned.")

    // A request is processed alone: no second request right after one is taken.
    `RTDC_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready, "Request taken while another is in progress.")

    // The table never reports more regions than it has slots.
    `RTDC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_out_valid,
        32'(o_regions_in_use) <= 32'(MAX_REGIONS), "Region count exceeds table size.")

endmodule

bind region_table_define_check_core rtdc_chk #(
    .MAX_REGIONS (MAX_REGIONS),
    .PAGE_SHIFT  (PAGE_SHIFT)
) u_rtdc_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_aligned_base   (o_aligned_base),
    .o_aligned_length (o_aligned_length),
    .o_regions_in_use (o_regions_in_use)
);

`default_nettype wire
